FILE: hw/rtl/lfps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line follower PID steering unit.
package lfps_pkg;

  // Register indexes on the configuration port (word address)
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_DUTY_LIMIT  = 3'd3;
  localparam logic [2:0] REG_SPEED       = 3'd4;
  localparam logic [2:0] REG_DERIV_HOLD  = 3'd5;

  localparam int PADDR_W = 5;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 14;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Reciprocals for truncating division by 100 and by 10
  localparam logic signed [MUL_B_W-1:0] DIV100_RECIP = 14'sd5243;
  localparam int                        DIV100_SHIFT = 19;
  localparam logic signed [MUL_B_W-1:0] DIV10_RECIP  = 14'sd6554;
  localparam int                        DIV10_SHIFT  = 16;

  // Integral clamp is 50 * duty_limit in hundredths
  localparam logic [15:0] ISUM_CLAMP_SCALE = 16'd50;

  typedef struct packed {
    logic [7:0] prop_gain;
    logic [7:0] integ_gain;
    logic [7:0] deriv_gain;
    logic [7:0] duty_limit;
    logic [3:0] speed_setting;
    logic [7:0] deriv_hold_steps;
  } cfg_t;

  typedef struct packed {
    logic signed [4:0] pos;
    logic              lost;
  } dec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IACC,
    ST_IDIV,
    ST_ICLAMP,
    ST_PROP,
    ST_SUM,
    ST_LMUL,
    ST_RMUL,
    ST_LDIV,
    ST_RDIV,
    ST_RFIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_INTEG,
    MUL_DERIV,
    MUL_IRECIP,
    MUL_PROP,
    MUL_LSPEED,
    MUL_RSPEED,
    MUL_LRECIP,
    MUL_RRECIP
  } mul_sel_t;

endpackage

FILE: hw/rtl/lfps_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration registers for gains, duty limit, speed and derivative hold.
module lfps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output lfps_pkg::cfg_t                cfg
);
  import lfps_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= 8'd7;
      cfg.integ_gain       <= 8'd5;
      cfg.deriv_gain       <= 8'd5;
      cfg.duty_limit       <= 8'd100;
      cfg.speed_setting    <= 4'd10;
      cfg.deriv_hold_steps <= 8'd2;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROP_GAIN:  cfg.prop_gain        <= pwdata[7:0];
        REG_INTEG_GAIN: cfg.integ_gain       <= pwdata[7:0];
        REG_DERIV_GAIN: cfg.deriv_gain       <= pwdata[7:0];
        REG_DUTY_LIMIT: cfg.duty_limit       <= pwdata[7:0];
        REG_SPEED:      cfg.speed_setting    <= pwdata[3:0];
        REG_DERIV_HOLD: cfg.deriv_hold_steps <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = {24'd0, cfg.prop_gain};
      REG_INTEG_GAIN: prdata = {24'd0, cfg.integ_gain};
      REG_DERIV_GAIN: prdata = {24'd0, cfg.deriv_gain};
      REG_DUTY_LIMIT: prdata = {24'd0, cfg.duty_limit};
      REG_SPEED:      prdata = {28'd0, cfg.speed_setting};
      REG_DERIV_HOLD: prdata = {24'd0, cfg.deriv_hold_steps};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/lfps_decode.sv
`timescale 1ns / 1ps
// Sensor pattern decoder with all-clear side memory and lost detection.
module lfps_decode (
  input  logic [7:0]        sensor_bits,
  input  logic signed [4:0] position_reg,
  input  logic              lost_flag,
  output lfps_pkg::dec_t    dec
);
  import lfps_pkg::*;

  logic signed [4:0] clear_pos;

  // All clear: recenter when lost or near the middle, snap far edges to the extreme
  always_comb begin
    if (lost_flag || (position_reg >= -5'sd1 && position_reg <= 5'sd1)) begin
      clear_pos = 5'sd0;
    end else if (position_reg <= -5'sd11) begin
      clear_pos = -5'sd13;
    end else if (position_reg >= 5'sd11) begin
      clear_pos = 5'sd13;
    end else begin
      clear_pos = position_reg;
    end
  end

  always_comb begin
    dec.lost = 1'b0;
    case (sensor_bits)
      8'h00:   dec.pos = clear_pos;
      8'h18:   dec.pos = 5'sd0;
      8'h01:   dec.pos = 5'sd11;
      8'h03:   dec.pos = 5'sd9;
      8'h02:   dec.pos = 5'sd7;
      8'h06:   dec.pos = 5'sd5;
      8'h04:   dec.pos = 5'sd3;
      8'h0C:   dec.pos = 5'sd2;
      8'h08:   dec.pos = 5'sd1;
      8'h80:   dec.pos = -5'sd11;
      8'hC0:   dec.pos = -5'sd9;
      8'h40:   dec.pos = -5'sd7;
      8'h60:   dec.pos = -5'sd5;
      8'h20:   dec.pos = -5'sd3;
      8'h30:   dec.pos = -5'sd2;
      8'h10:   dec.pos = -5'sd1;
      default: begin
        dec.pos  = position_reg;
        dec.lost = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lfps_mul_unit.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module lfps_mul_unit (
  input  logic                                  clk,
  input  logic signed [lfps_pkg::MUL_A_W-1:0]   a,
  input  logic signed [lfps_pkg::MUL_B_W-1:0]   b,
  output logic signed [lfps_pkg::MUL_P_W-1:0]   p
);
  import lfps_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: hw/rtl/line_follow_pid_steering_unit.sv
`timescale 1ns / 1ps
// Line follower PID steering unit: decode, PID update and differential drive mixing.
// An item that runs a PID update takes eight passes through the one shared multiplier plus
// clamp, sum and finish steps before its result is loaded. Without an update the sequencer
// goes from acceptance straight to its done step. A stalled result holds the sequencer in its
// last step; one may wait in the output register while the next item is accepted.
// Synchronous reset restores gains, controller state and duties to their defaults and leaves
// the line marked lost.
module line_follow_pid_steering_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    sensor_bits,
  input  logic                          period_elapsed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    left_duty,
  output logic                          left_reverse,
  output logic [7:0]                    right_duty,
  output logic                          right_reverse,
  output logic signed [4:0]             track_position,
  output logic                          line_lost,
  output logic                          control_ran
);
  import lfps_pkg::*;

  cfg_t     cfg;
  dec_t     dec;
  state_t   state, state_next;
  mul_sel_t mul_sel;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic signed [4:0]  position_reg;
  logic               lost_flag;
  logic signed [4:0]  prev_error;
  logic signed [15:0] integral_sum;
  logic signed [12:0] prop_term;
  logic signed [13:0] deriv_term;
  logic [7:0]         hold_count;
  logic [7:0]         left_duty_reg, right_duty_reg;
  logic               left_rev_reg, right_rev_reg;
  logic               ran_reg;
  logic signed [8:0]  iterm;
  logic signed [9:0]  u_reg;
  logic [13:0]        lmag, rmag;
  logic               lneg, rneg;

  logic               in_accept;
  logic               run_pid;
  logic               out_load;
  logic               err_changed;
  logic signed [5:0]  err_diff;
  logic [15:0]        isum_mag;
  logic signed [10:0] lim_s, u_ext, v_left, v_right;
  logic signed [9:0]  iterm_raw, half_s;
  logic [7:0]         iquot;
  logic [15:0]        isum_clamp;
  logic signed [15:0] u_sum, lim_w;
  logic signed [14:0] spd_prod;
  logic [13:0]        prod_mag;
  logic [10:0]        quot10;
  logic [7:0]         duty_cap;
  logic [7:0]         hold_start;

  lfps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfps_decode u_decode (
    .sensor_bits  (sensor_bits),
    .position_reg (position_reg),
    .lost_flag    (lost_flag),
    .dec          (dec)
  );

  lfps_mul_unit u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_accept = in_valid & ~in_stall;
  assign run_pid   = ~dec.lost & (period_elapsed | (dec.pos != prev_error));

  // Datapath helpers
  assign err_changed = position_reg != prev_error;
  assign err_diff    = 6'(position_reg) - 6'(prev_error);
  assign isum_mag    = integral_sum[15] ? 16'(-integral_sum) : 16'(integral_sum);
  assign lim_s       = $signed({3'b000, cfg.duty_limit});
  assign u_ext       = 11'(u_reg);
  assign v_left      = u_reg[9] ? lim_s + (u_ext <<< 1) : lim_s + u_ext;
  assign v_right     = u_reg[9] ? lim_s - u_ext : lim_s - (u_ext <<< 1);

  assign iquot       = mul_p[DIV100_SHIFT+7:DIV100_SHIFT];
  assign iterm_raw   = integral_sum[15] ? -$signed({2'b00, iquot}) : $signed({2'b00, iquot});
  assign half_s      = $signed({3'b000, cfg.duty_limit[7:1]});
  assign isum_clamp  = 16'(cfg.duty_limit) * ISUM_CLAMP_SCALE;

  assign lim_w       = 16'(lim_s);
  assign u_sum       = 16'(prop_term) + 16'(iterm) + 16'(deriv_term);

  assign spd_prod    = mul_p[14:0];
  assign prod_mag    = spd_prod[14] ? 14'(-spd_prod) : spd_prod[13:0];
  assign quot10      = mul_p[DIV10_SHIFT+10:DIV10_SHIFT];
  assign duty_cap    = (quot10 > {3'b000, cfg.duty_limit}) ? cfg.duty_limit : quot10[7:0];

  assign hold_start  = err_changed ? cfg.deriv_hold_steps : hold_count;

  // Shared multiplier operand select
  always_comb begin
    case (mul_sel)
      MUL_INTEG: begin
        mul_a = $signed({8'd0, cfg.integ_gain});
        mul_b = MUL_B_W'(position_reg);
      end
      MUL_DERIV: begin
        mul_a = $signed({8'd0, cfg.deriv_gain});
        mul_b = MUL_B_W'(err_diff);
      end
      MUL_IRECIP: begin
        mul_a = $signed(isum_mag);
        mul_b = DIV100_RECIP;
      end
      MUL_PROP: begin
        mul_a = $signed({8'd0, cfg.prop_gain});
        mul_b = MUL_B_W'(position_reg);
      end
      MUL_LSPEED: begin
        mul_a = $signed({12'd0, cfg.speed_setting});
        mul_b = MUL_B_W'(v_left);
      end
      MUL_RSPEED: begin
        mul_a = $signed({12'd0, cfg.speed_setting});
        mul_b = MUL_B_W'(v_right);
      end
      MUL_LRECIP: begin
        mul_a = $signed({2'b00, lmag});
        mul_b = DIV10_RECIP;
      end
      MUL_RRECIP: begin
        mul_a = $signed({2'b00, rmag});
        mul_b = DIV10_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = run_pid ? ST_IMUL : ST_DONE;
      ST_IMUL:   state_next = ST_IACC;
      ST_IACC:   state_next = ST_IDIV;
      ST_IDIV:   state_next = ST_ICLAMP;
      ST_ICLAMP: state_next = ST_PROP;
      ST_PROP:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_LMUL;
      ST_LMUL:   state_next = ST_RMUL;
      ST_RMUL:   state_next = ST_LDIV;
      ST_LDIV:   state_next = ST_RDIV;
      ST_RDIV:   state_next = ST_RFIN;
      ST_RFIN:   state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    mul_sel  = MUL_INTEG;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_IMUL:   mul_sel  = MUL_INTEG;
      ST_IACC:   mul_sel  = MUL_DERIV;
      ST_IDIV:   mul_sel  = MUL_IRECIP;
      ST_ICLAMP: mul_sel  = MUL_PROP;
      ST_LMUL:   mul_sel  = MUL_LSPEED;
      ST_RMUL:   mul_sel  = MUL_RSPEED;
      ST_LDIV:   mul_sel  = MUL_LRECIP;
      ST_RDIV:   mul_sel  = MUL_RRECIP;
      ST_DONE:   out_load = ~out_valid | ~out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= 5'sd0;
      lost_flag      <= 1'b1;
      prev_error     <= 5'sd0;
      integral_sum   <= 16'sd0;
      prop_term      <= 13'sd0;
      deriv_term     <= 14'sd0;
      hold_count     <= 8'd0;
      left_duty_reg  <= 8'd0;
      right_duty_reg <= 8'd0;
      left_rev_reg   <= 1'b0;
      right_rev_reg  <= 1'b0;
      ran_reg        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            position_reg <= dec.pos;
            lost_flag    <= dec.lost;
            ran_reg      <= run_pid;
            if (dec.lost) begin
              left_duty_reg  <= 8'd0;
              right_duty_reg <= 8'd0;
            end
          end
        end
        ST_IACC: integral_sum <= integral_sum + mul_p[15:0];
        ST_IDIV: if (err_changed) deriv_term <= mul_p[13:0];
        ST_ICLAMP: begin
          if (iterm_raw > half_s) begin
            integral_sum <= $signed(isum_clamp);
          end else if (iterm_raw < -half_s) begin
            integral_sum <= -$signed(isum_clamp);
          end
        end
        ST_PROP: begin
          if (err_changed) begin
            prop_term  <= mul_p[12:0];
            prev_error <= position_reg;
          end
          // Count down the derivative hold; drop the term once it runs out
          if (hold_start != 8'd0) begin
            hold_count <= hold_start - 8'd1;
          end else begin
            hold_count <= 8'd0;
            deriv_term <= 14'sd0;
          end
        end
        ST_RDIV: begin
          left_duty_reg <= duty_cap;
          left_rev_reg  <= lneg & (quot10 != 11'd0);
        end
        ST_RFIN: begin
          right_duty_reg <= duty_cap;
          right_rev_reg  <= rneg & (quot10 != 11'd0);
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_ICLAMP: begin
        if (iterm_raw > half_s) begin
          iterm <= 9'(half_s);
        end else if (iterm_raw < -half_s) begin
          iterm <= 9'(-half_s);
        end else begin
          iterm <= 9'(iterm_raw);
        end
      end
      ST_SUM: begin
        if (u_sum > lim_w) begin
          u_reg <= 10'(lim_w);
        end else if (u_sum < -lim_w) begin
          u_reg <= 10'(-lim_w);
        end else begin
          u_reg <= 10'(u_sum);
        end
      end
      ST_RMUL: begin
        lmag <= prod_mag;
        lneg <= spd_prod[14];
      end
      ST_LDIV: begin
        rmag <= prod_mag;
        rneg <= spd_prod[14];
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_duty      <= left_duty_reg;
      left_reverse   <= left_rev_reg;
      right_duty     <= right_duty_reg;
      right_reverse  <= right_rev_reg;
      track_position <= lost_flag ? 5'sd0 : position_reg;
      line_lost      <= lost_flag;
      control_ran    <= ran_reg;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted request did not make the unit busy");

  a_lost_no_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_lost |-> left_duty == 8'd0 && right_duty == 8'd0
                               && track_position == 5'sd0 && !control_ran)
    else $error("lost line still drives motors or reports an update");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("finished request did not reach the output register");
`endif

endmodule
